>>> rtl/wildcard_relative_byte_search_macros.svh
// assertion macros for the byte search block
// used by the top level, expects clk and rst_n in scope
`ifndef WILDCARD_RELATIVE_BYTE_SEARCH_MACROS_SVH
`define WILDCARD_RELATIVE_BYTE_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define WRBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WRBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WRBS_ASSERT_SAME(label, ante, cons)
`define WRBS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/wrbs_pkg.sv
// shared types, register codes and byte helpers for the byte search block
// no dependencies
`default_nettype none
package wrbs_pkg;

  localparam int PAT_BYTES = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W = 5;
  localparam int OFFS_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_LOW    = 3'd1,
    REG_PATTERN_HIGH   = 3'd2,
    REG_CASE_FOLD      = 3'd3,
    REG_WILDCARD_EN    = 3'd4,
    REG_WILDCARD_CHAR  = 3'd5,
    REG_RELATIVE_EN    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]               pattern_length;
    logic [PAT_BYTES-1:0][7:0]      pattern;
    logic                           case_fold_enable;
    logic                           wildcard_enable;
    logic [7:0]                     wildcard_char;
    logic                           relative_enable;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [OFFS_W-1:0] offset;
  } match_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/wrbs_in_if.sv
// input channel of the byte search block: one buffer byte per request
// no dependencies
`default_nettype none
interface wrbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source(output valid, output data_byte, output end_of_buffer, input ready);
  modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface
`default_nettype wire

>>> rtl/wrbs_out_if.sv
// result channel of the byte search block: found flag and window offset
// no dependencies
`default_nettype none
interface wrbs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source(output valid, output found, output match_offset, input ready);
  modport sink(input valid, input found, input match_offset, output ready);
endinterface
`default_nettype wire

>>> rtl/wildcard_relative_byte_search.sv
// An accepted byte request is held in the stage register, its result in the
// result register. Throughput: one byte per cycle unless input is stalled;
// the window compare is a single stage between the window shift register and the result register.
// The block stalls input only while a result is held in both stages.
// Reset (rst_n, synchronous): registers take their reset values, pipeline
// empties and the first byte starts a new buffer with a zeroed window.
`default_nettype none
`include "wildcard_relative_byte_search_macros.svh"
module wildcard_relative_byte_search #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wrbs_in_if.sink                             in_ch,
  wrbs_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [wrbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wrbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [wrbs_pkg::OFFS_W-1:0] SEEN_MAX = '1;

  wrbs_pkg::cfg_t               cfg_r;
  logic [MAX_PATTERN-1:0][7:0]  win_r;
  logic [MAX_PATTERN-1:0][7:0]  win_nxt;
  logic [wrbs_pkg::OFFS_W-1:0]  count_r;
  logic [wrbs_pkg::OFFS_W-1:0]  seen_cur;
  logic                         restart_r;
  logic                         reported_r;
  logic                         s1_v_r;
  logic                         s1_eob_r;
  logic                         s1_fresh_r;
  logic [wrbs_pkg::OFFS_W-1:0]  s1_seen_r;
  logic                         out_v_r;
  logic                         out_found_r;
  logic [wrbs_pkg::OFFS_W-1:0]  out_offs_r;

  wrbs_pkg::match_t             m;
  logic                         eff_reported;
  logic                         s1_hit;
  logic                         s1_res;
  logic                         out_free;
  logic                         s1_can_move;
  logic                         s1_fire;
  logic                         in_fire;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_length <= wrbs_pkg::LEN_W'(1);
      cfg_r.pattern        <= '0;
      cfg_r.case_fold_enable <= 1'b0;
      cfg_r.wildcard_enable  <= 1'b0;
      cfg_r.wildcard_char    <= 8'h00;
      cfg_r.relative_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (wrbs_pkg::reg_idx_t'(cfg_index))
        wrbs_pkg::REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_data[wrbs_pkg::LEN_W-1:0];
        wrbs_pkg::REG_PATTERN_LOW:    cfg_r.pattern[7:0]   <= cfg_data;
        wrbs_pkg::REG_PATTERN_HIGH:   cfg_r.pattern[15:8]  <= cfg_data;
        wrbs_pkg::REG_CASE_FOLD:      cfg_r.case_fold_enable <= cfg_data[0];
        wrbs_pkg::REG_WILDCARD_EN:    cfg_r.wildcard_enable  <= cfg_data[0];
        wrbs_pkg::REG_WILDCARD_CHAR:  cfg_r.wildcard_char    <= cfg_data[7:0];
        wrbs_pkg::REG_RELATIVE_EN:    cfg_r.relative_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wrbs_matcher #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_matcher (
    .cfg    (cfg_r),
    .window (win_r),
    .seen   (s1_seen_r),
    .result (m)
  );

  assign eff_reported = s1_fresh_r ? 1'b0 : reported_r;
  assign s1_hit       = s1_v_r && !eff_reported && m.hit;
  assign s1_res       = s1_v_r && !eff_reported && (m.hit || s1_eob_r);
  assign out_free     = !out_v_r || out_ch.ready;
  assign s1_can_move  = !s1_v_r || !s1_res || out_free;
  assign s1_fire      = s1_v_r && s1_can_move;
  assign in_ch.ready  = s1_can_move;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // a new buffer starts from a zeroed window and count
  always_comb begin
    seen_cur = restart_r ? '0 : count_r;
    for (int i = MAX_PATTERN - 1; i > 0; i--) begin
      win_nxt[i] = restart_r ? 8'h00 : win_r[i-1];
    end
    win_nxt[0] = in_ch.data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r  <= 1'b1;
      reported_r <= 1'b0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        restart_r  <= in_ch.end_of_buffer;
        s1_v_r     <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r     <= 1'b0;
      end
      if (s1_fire) begin
        reported_r <= eff_reported || m.hit;
      end
      if (s1_fire && s1_res) begin
        out_v_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r    <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r      <= win_nxt;
      s1_seen_r  <= seen_cur;
      s1_eob_r   <= in_ch.end_of_buffer;
      s1_fresh_r <= restart_r;
      count_r    <= (seen_cur == SEEN_MAX) ? seen_cur : seen_cur + 1'b1;
    end
    if (s1_fire && s1_res) begin
      out_found_r <= m.hit;
      out_offs_r  <= m.hit ? m.offset : '0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.match_offset = out_offs_r;

  `WRBS_ASSERT_NEXT(a_in_to_stage, in_fire, s1_v_r)
  `WRBS_ASSERT_SAME(a_stall_blocks_in, s1_v_r && !s1_can_move, !in_ch.ready)
  `WRBS_ASSERT_NEXT(a_hit_marks_reported, s1_fire && s1_hit, reported_r)
  `WRBS_ASSERT_NEXT(a_eob_restarts, in_fire && in_ch.end_of_buffer, restart_r)
  `WRBS_ASSERT_SAME(a_miss_offset_zero, out_v_r && !out_found_r, out_offs_r == '0)

endmodule
`default_nettype wire

>>> rtl/wrbs_matcher.sv
// window compare: all pattern positions checked in parallel against the window
// depends on wrbs_pkg
`default_nettype none
module wrbs_matcher #(
  parameter int MAX_PATTERN = 16
) (
  input  wrbs_pkg::cfg_t                   cfg,
  input  logic [MAX_PATTERN-1:0][7:0]      window,
  input  logic [wrbs_pkg::OFFS_W-1:0]      seen,
  output wrbs_pkg::match_t                 result
);

  localparam int IW = $clog2(MAX_PATTERN);

  logic [wrbs_pkg::LEN_W-1:0] len;
  logic [wrbs_pkg::LEN_W-1:0] len_m1;
  logic [MAX_PATTERN:0][7:0]  pat;
  logic [MAX_PATTERN:0][7:0]  wb;
  logic                       all_ok;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = wrbs_pkg::LEN_W'(1);
    end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
      len = wrbs_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      len = cfg.pattern_length;
    end
    len_m1 = len - wrbs_pkg::LEN_W'(1);
  end

  // pattern bytes and window bytes in window order, zero beyond range
  always_comb begin
    int pos;
    for (int j = 0; j <= MAX_PATTERN; j++) begin
      pos = int'(len) - 1 - j;
      pat[j] = (j < wrbs_pkg::PAT_BYTES) ? cfg.pattern[4'(j)] : 8'h00;
      wb[j]  = (pos >= 0 && pos < MAX_PATTERN) ? window[pos[IW-1:0]] : 8'h00;
    end
  end

  always_comb begin
    logic       active;
    logic       wild;
    logic       pos_ok;
    logic [8:0] dw;
    logic [8:0] dp;
    all_ok = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      active = cfg.relative_enable ? (k < int'(len) - 1) : (k < int'(len));
      wild   = cfg.wildcard_enable && (pat[k] == cfg.wildcard_char);
      dw     = {1'b0, wb[k]} - {1'b0, wb[k+1]};
      dp     = {1'b0, pat[k]} - {1'b0, pat[k+1]};
      if (cfg.relative_enable) begin
        pos_ok = (dw == dp);
      end else if (cfg.case_fold_enable && wrbs_pkg::is_letter(pat[k])) begin
        pos_ok = (wrbs_pkg::to_lower(wb[k]) == wrbs_pkg::to_lower(pat[k]));
      end else begin
        pos_ok = (wb[k] == pat[k]);
      end
      all_ok = all_ok && (!active || wild || pos_ok);
    end
  end

  always_comb begin
    logic [wrbs_pkg::OFFS_W-1:0] len_m1_w;
    len_m1_w      = {{(wrbs_pkg::OFFS_W-wrbs_pkg::LEN_W){1'b0}}, len_m1};
    result.hit    = all_ok && (seen >= len_m1_w)
                    && (!cfg.relative_enable || (len >= wrbs_pkg::LEN_W'(2)));
    result.offset = seen - len_m1_w;
  end

endmodule
`default_nettype wire

>>> sim/wrbs_search_check.sv
`timescale 1ns / 1ps
// result checker for wildcard_relative_byte_search: watches the byte, result and register
// ports, keeps its own search state and compares each result with the oldest one predicted
// depends on wrbs_pkg
module wrbs_search_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_end_of_buffer,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_found,
  input  logic [wrbs_pkg::OFFS_W-1:0]     out_match_offset,
  input  logic                            cfg_we,
  input  logic [wrbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrbs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              failures,
  output int                              pending
);

  // register copies
  logic [wrbs_pkg::LEN_W-1:0]       len_q;
  logic [8*wrbs_pkg::PAT_BYTES-1:0] pattern_q;
  logic                             fold_q;
  logic                             wild_q;
  logic [7:0]                       wchar_q;
  logic                             rel_q;

  // search state, history[0] is the newest byte
  logic [7:0]                  history [wrbs_pkg::PAT_BYTES];
  logic [wrbs_pkg::OFFS_W-1:0] bytes_seen;
  logic                        reported;

  wrbs_pkg::match_t expected_matches[$];
  wrbs_pkg::match_t want;

  function automatic bit alpha_byte(input logic [7:0] c);
    return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7a);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
  endfunction

  function automatic int window_len();
    if (len_q == '0) return 1;
    if (int'(len_q) > wrbs_pkg::PAT_BYTES) return wrbs_pkg::PAT_BYTES;
    return int'(len_q);
  endfunction

  function automatic bit window_hit(input int len);
    int count;
    int diff_win;
    int diff_pat;
    logic [7:0] pat_b;
    count = len;
    if (rel_q) begin
      if (len < 2) return 1'b0;
      count = len - 1;
    end
    for (int k = 0; k < count; k++) begin
      pat_b = pattern_q[8*k +: 8];
      if (wild_q && pat_b == wchar_q) continue;
      if (rel_q) begin
        diff_win = int'(history[len-1-k]) - int'(history[len-2-k]);
        diff_pat = int'(pat_b) - int'(pattern_q[8*(k+1) +: 8]);
        if (diff_win != diff_pat) return 1'b0;
      end else if (fold_q && alpha_byte(pat_b)) begin
        if (fold_case(history[len-1-k]) != fold_case(pat_b)) return 1'b0;
      end else if (history[len-1-k] != pat_b) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_window();
    for (int i = 0; i < wrbs_pkg::PAT_BYTES; i++) history[i] = '0;
    bytes_seen = '0;
    reported = 1'b0;
  endtask

  task automatic advance_search(input logic [7:0] data_b, input logic last);
    int len;
    wrbs_pkg::match_t res;
    for (int i = wrbs_pkg::PAT_BYTES - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = data_b;
    if (!reported) begin
      len = window_len();
      if (bytes_seen >= wrbs_pkg::OFFS_W'(len - 1) && window_hit(len)) begin
        res.hit = 1'b1;
        res.offset = bytes_seen - wrbs_pkg::OFFS_W'(len - 1);
        reported = 1'b1;
        expected_matches.push_back(res);
      end else if (last) begin
        res = '0;
        expected_matches.push_back(res);
      end
    end
    if (bytes_seen != '1) bytes_seen = bytes_seen + 1'b1;
    if (last) clear_window();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("%0t mismatch on %s: got %0h, predicted %0h", $realtime, what, got, exp_v);
    failures++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      len_q = 5'd1;
      pattern_q = '0;
      fold_q = 1'b0;
      wild_q = 1'b0;
      wchar_q = '0;
      rel_q = 1'b0;
      clear_window();
      expected_matches.delete();
      failures = 0;
    end else begin
      // results leave through the stage and result registers after their request, so retire before adding
      if (out_valid && out_ready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch("result with none pending, offset", out_match_offset, '0);
        end else begin
          want = expected_matches.pop_front();
          if (out_found !== want.hit)
            report_mismatch("found", {31'b0, out_found}, {31'b0, want.hit});
          if (out_match_offset !== want.offset)
            report_mismatch("match_offset", out_match_offset, want.offset);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          wrbs_pkg::REG_PATTERN_LENGTH: len_q = cfg_data[wrbs_pkg::LEN_W-1:0];
          wrbs_pkg::REG_PATTERN_LOW:    pattern_q[63:0] = cfg_data;
          wrbs_pkg::REG_PATTERN_HIGH:   pattern_q[127:64] = cfg_data;
          wrbs_pkg::REG_CASE_FOLD:      fold_q = cfg_data[0];
          wrbs_pkg::REG_WILDCARD_EN:    wild_q = cfg_data[0];
          wrbs_pkg::REG_WILDCARD_CHAR:  wchar_q = cfg_data[7:0];
          wrbs_pkg::REG_RELATIVE_EN:    rel_q = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_search(in_data_byte, in_end_of_buffer);
    end
    pending = expected_matches.size();
  end

endmodule

>>> sim/tb_wildcard_relative_byte_search.sv
`timescale 1ns / 1ps
// testbench top for wildcard_relative_byte_search: clock, reset, register writes, byte
// requests with planted windows, result-side stalls and the verdict
// depends on wrbs_pkg, wrbs_in_if, wrbs_out_if, wrbs_search_check and the block
module tb_wildcard_relative_byte_search;

  localparam int TOTAL_ITEMS = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [wrbs_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [wrbs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wrbs_pkg::CFG_DATA_W-1:0] cfg_data;

  int failures;
  int results_due;
  int items_sent = 0;
  int cycle_count = 0;
  bit send_gaps_on = 1'b1;
  bit take_gaps_on = 1'b1;

  // settings as last written, for planting windows that should hit
  logic [wrbs_pkg::LEN_W-1:0]       cur_len;
  logic [8*wrbs_pkg::PAT_BYTES-1:0] cur_pat;
  logic                             cur_fold;
  logic                             cur_wild;
  logic [7:0]                       cur_wchar;
  logic                             cur_rel;

  wrbs_in_if  in_ch ();
  wrbs_out_if out_ch ();

  wildcard_relative_byte_search #(.MAX_PATTERN(wrbs_pkg::PAT_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wrbs_search_check search_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_end_of_buffer (in_ch.end_of_buffer),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_found        (out_ch.found),
    .out_match_offset (out_ch.match_offset),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .failures         (failures),
    .pending          (results_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[wildcard_relative_byte_search] ERROR");
      $finish;
    end
  end

  // result side: a random stall before each result, none in quiet phases
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = take_gaps_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // leaves the write enable high, end_writes drops it
  task automatic write_reg(input logic [wrbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wrbs_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= value;
    in_ch.end_of_buffer <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // holds off requests until every predicted result has been taken
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_random_config(input int phase);
    int pick;
    logic [7:0] v;
    pick = $urandom_range(0, 19);
    if (pick < 12) cur_len = wrbs_pkg::LEN_W'($urandom_range(1, 5));
    else if (pick < 17) cur_len = wrbs_pkg::LEN_W'($urandom_range(6, 16));
    else if (pick < 18) cur_len = '0;
    else cur_len = wrbs_pkg::LEN_W'($urandom_range(17, 31));
    for (int k = 0; k < wrbs_pkg::PAT_BYTES; k++) begin
      case ($urandom_range(0, 3))
        0: v = 8'($urandom);
        1: begin
          v = 8'($urandom_range(8'h41, 8'h5a));
          if ($urandom_range(0, 1) != 0) v = v | 8'h20;
        end
        2: v = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        default: begin
          // neighbours of the letter ranges
          pick = $urandom_range(0, 3);
          v = (pick[1] ? 8'h60 : 8'h40) + (pick[0] ? 8'h1b : 8'h00);
        end
      endcase
      cur_pat[8*k +: 8] = v;
    end
    case (phase)
      0: cur_len = 5'd16;
      1: cur_len = '0;
      2: cur_len = 5'd31;
      3: cur_pat = '1;
      4: cur_pat = '0;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: cur_wchar = cur_pat[8*$urandom_range(0, 3) +: 8];
      1: cur_wchar = 8'h00;
      2: cur_wchar = 8'hff;
      default: cur_wchar = 8'($urandom);
    endcase
    cur_fold = 1'($urandom_range(0, 1));
    cur_wild = 1'($urandom_range(0, 1));
    cur_rel = ($urandom_range(0, 2) == 0);
    write_reg(wrbs_pkg::REG_PATTERN_LENGTH, wrbs_pkg::CFG_DATA_W'(cur_len));
    write_reg(wrbs_pkg::REG_PATTERN_LOW, cur_pat[63:0]);
    write_reg(wrbs_pkg::REG_PATTERN_HIGH, cur_pat[127:64]);
    write_reg(wrbs_pkg::REG_CASE_FOLD, wrbs_pkg::CFG_DATA_W'(cur_fold));
    write_reg(wrbs_pkg::REG_WILDCARD_EN, wrbs_pkg::CFG_DATA_W'(cur_wild));
    write_reg(wrbs_pkg::REG_WILDCARD_CHAR, wrbs_pkg::CFG_DATA_W'(cur_wchar));
    write_reg(wrbs_pkg::REG_RELATIVE_EN, wrbs_pkg::CFG_DATA_W'(cur_rel));
    end_writes();
  endtask

  // one buffer of random bytes, usually with a matching window planted in it
  task automatic send_buffer();
    logic [7:0] stream[$];
    logic [7:0] v;
    int n;
    int eff;
    int pos;
    int lo;
    int hi;
    int shift;
    int flip_at;
    bit narrow;
    eff = (cur_len == '0) ? 1 :
          (int'(cur_len) > wrbs_pkg::PAT_BYTES) ? wrbs_pkg::PAT_BYTES : int'(cur_len);
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 64);
    narrow = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++) begin
      if (narrow) begin
        v = cur_pat[8*$urandom_range(0, eff - 1) +: 8];
        if ($urandom_range(0, 3) == 0) v = v ^ 8'h20;
      end else begin
        v = 8'($urandom);
      end
      stream.push_back(v);
    end
    if (n >= eff && $urandom_range(0, 3) != 0) begin
      pos = $urandom_range(0, n - eff);
      lo = 255;
      hi = 0;
      for (int k = 0; k < eff; k++) begin
        if (int'(cur_pat[8*k +: 8]) < lo) lo = int'(cur_pat[8*k +: 8]);
        if (int'(cur_pat[8*k +: 8]) > hi) hi = int'(cur_pat[8*k +: 8]);
      end
      // relative windows keep the differences, so shift the whole window without wrapping
      shift = int'($urandom_range(0, 255 - hi + lo)) - lo;
      for (int k = 0; k < eff; k++) begin
        v = cur_pat[8*k +: 8];
        if (cur_rel) v = v + shift[7:0];
        else if (cur_wild && v == cur_wchar) v = 8'($urandom);
        else if (cur_fold && ((v | 8'h20) >= 8'h61) && ((v | 8'h20) <= 8'h7a)
                 && $urandom_range(0, 1) != 0) v = v ^ 8'h20;
        stream[pos + k] = v;
      end
      if ($urandom_range(0, 4) == 0) begin
        flip_at = pos + $urandom_range(0, eff - 1);
        stream[flip_at] = stream[flip_at] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < n; i++) send_byte(stream[i], i == n - 1);
  endtask

  initial begin
    int phase;
    int n_buffers;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= wrbs_pkg::REG_PATTERN_LENGTH;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.end_of_buffer <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one zero byte, later bytes of the buffer absorbed
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'haa, 1'b1);
    wait_idle();
    // zero length acts as one
    write_reg(wrbs_pkg::REG_PATTERN_LENGTH, 64'd0);
    end_writes();
    send_byte(8'h00, 1'b1);
    wait_idle();
    // case folding on letters only
    write_reg(wrbs_pkg::REG_PATTERN_LENGTH, 64'd3);
    write_reg(wrbs_pkg::REG_PATTERN_LOW, 64'h5a4061);
    write_reg(wrbs_pkg::REG_CASE_FOLD, 64'd1);
    end_writes();
    send_byte(8'h41, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h7a, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7a, 1'b1);
    wait_idle();
    // relative search below two bytes never hits
    write_reg(wrbs_pkg::REG_RELATIVE_EN, 64'd1);
    write_reg(wrbs_pkg::REG_PATTERN_LENGTH, 64'd1);
    end_writes();
    send_byte(8'h00, 1'b1);
    wait_idle();
    // largest negative difference
    write_reg(wrbs_pkg::REG_PATTERN_LENGTH, 64'd2);
    write_reg(wrbs_pkg::REG_PATTERN_LOW, 64'hff00);
    end_writes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    wait_idle();
    // wildcard position skipped
    write_reg(wrbs_pkg::REG_RELATIVE_EN, 64'd0);
    write_reg(wrbs_pkg::REG_CASE_FOLD, 64'd0);
    write_reg(wrbs_pkg::REG_WILDCARD_EN, 64'd1);
    write_reg(wrbs_pkg::REG_WILDCARD_CHAR, 64'hff);
    write_reg(wrbs_pkg::REG_PATTERN_LOW, 64'h00ff);
    end_writes();
    send_byte(8'h37, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
    // unused index must change nothing
    write_reg(REG_SPARE, '1);
    write_reg(wrbs_pkg::REG_PATTERN_HIGH, '1);
    end_writes();
    send_byte(8'h01, 1'b1);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      wait_idle();
      apply_random_config(phase);
      send_gaps_on = ($urandom_range(0, 3) != 0);
      take_gaps_on = ($urandom_range(0, 3) != 0);
      n_buffers = $urandom_range(2, 10);
      for (int b = 0; b < n_buffers && items_sent < TOTAL_ITEMS; b++) send_buffer();
      phase++;
    end
    wait_idle();

    if (failures == 0)
      $display("[wildcard_relative_byte_search] OK");
    else
      $display("[wildcard_relative_byte_search] ERROR");
    $finish;
  end

endmodule
